[hdl/rsa_mexp_pkg.sv]
// Shared types and constants of the RSA modular exponentiation unit.
package rsa_mexp_pkg;

  // Operation selector carried on the input tuser
  typedef enum logic [1:0] {
    FN_ENCRYPT = 2'd0,
    FN_DECRYPT = 2'd1,
    FN_SIGN    = 2'd2,
    FN_VERIFY  = 2'd3
  } func_t;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_MODULUS     = 2'd0,
    REG_PUBLIC_EXP  = 2'd1,
    REG_PRIVATE_EXP = 2'd2
  } reg_idx_t;

  // Exponentiation sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_GO,
    ST_RED_WAIT,
    ST_BIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_SQR_GO,
    ST_SQR_WAIT,
    ST_DONE
  } state_t;

  // Status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

  // Key built from primes 101 and 103 with e = 7
  localparam logic [31:0] RESET_MODULUS     = 32'd10403;
  localparam logic [31:0] RESET_PUBLIC_EXP  = 32'd7;
  localparam logic [31:0] RESET_PRIVATE_EXP = 32'd8743;

  localparam logic [7:0] BYTE_MASK = 8'hFF;

endpackage

[hdl/rsa_mexp_modmul.sv]
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
module rsa_mexp_modmul #(
  parameter int WORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [WORD_BITS-1:0]         x,
  input  logic [WORD_BITS-1:0]         y,
  input  logic [WORD_BITS-1:0]         n,
  output rsa_mexp_pkg::mm_status_t     stat,
  output logic [WORD_BITS-1:0]         p
);

  localparam int CntW = $clog2(WORD_BITS);

  logic                 busy;
  logic                 done;
  logic [CntW-1:0]      cnt;
  logic [WORD_BITS-1:0] r;
  logic [WORD_BITS-1:0] x_q;
  logic [WORD_BITS-1:0] y_q;
  logic [WORD_BITS-1:0] n_q;

  logic [WORD_BITS:0]   n_ext;
  logic [WORD_BITS:0]   dbl;
  logic [WORD_BITS:0]   dbl_red;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   sum_red;

  // One step: r = (2r + bit*x) mod n, with r and x below n
  always_comb begin
    n_ext   = {1'b0, n_q};
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= n_ext) ? (dbl - n_ext) : dbl;
    sum     = dbl_red + (y_q[WORD_BITS-1] ? {1'b0, x_q} : '0);
    sum_red = (sum >= n_ext) ? (sum - n_ext) : sum;
  end

  // Control: busy while the counter runs down from WORD_BITS-1 to zero, then pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CntW'(WORD_BITS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: latch operands, scan multiplier from the top bit
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      x_q <= x;
      y_q <= y;
      n_q <= n;
      r   <= '0;
    end else if (busy) begin
      r   <= sum_red[WORD_BITS-1:0];
      y_q <= {y_q[WORD_BITS-2:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign p         = r;

endmodule

[hdl/rsa_mexp_seq.sv]
// Square-and-multiply sequencer driving the shared modular multiplier.
module rsa_mexp_seq #(
  parameter int WORD_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  rsa_mexp_pkg::func_t      in_func,
  input  logic [WORD_BITS-1:0]     in_value,
  input  logic [WORD_BITS-1:0]     in_hash,
  input  logic [WORD_BITS-1:0]     modulus,
  input  logic [WORD_BITS-1:0]     public_exponent,
  input  logic [WORD_BITS-1:0]     private_exponent,
  output logic                     res_valid,
  input  logic                     res_ready,
  output logic [WORD_BITS-1:0]     res_word,
  output logic                     res_match,
  output logic                     mm_start,
  output logic [WORD_BITS-1:0]     mm_x,
  output logic [WORD_BITS-1:0]     mm_y,
  output logic [WORD_BITS-1:0]     mm_n,
  input  rsa_mexp_pkg::mm_status_t mm_stat,
  input  logic [WORD_BITS-1:0]     mm_p
);

  localparam int BitsW = $clog2(WORD_BITS + 1);

  rsa_mexp_pkg::state_t state;
  rsa_mexp_pkg::state_t state_next;

  rsa_mexp_pkg::func_t  func_q;
  logic [WORD_BITS-1:0] hash_q;
  logic [WORD_BITS-1:0] base;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] expo;
  logic [BitsW-1:0]     bits_left;
  logic                 accept;
  logic                 small_mod;

  assign accept    = in_valid && in_ready;
  assign small_mod = modulus < WORD_BITS'(2);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsa_mexp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rsa_mexp_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = small_mod ? rsa_mexp_pkg::ST_DONE : rsa_mexp_pkg::ST_RED_GO;
        end
      end
      rsa_mexp_pkg::ST_RED_GO:   state_next = rsa_mexp_pkg::ST_RED_WAIT;
      rsa_mexp_pkg::ST_RED_WAIT: begin
        if (mm_stat.done) state_next = rsa_mexp_pkg::ST_BIT;
      end
      rsa_mexp_pkg::ST_BIT: begin
        if (bits_left == '0) begin
          state_next = rsa_mexp_pkg::ST_DONE;
        end else if (expo[0]) begin
          state_next = rsa_mexp_pkg::ST_MUL_GO;
        end else begin
          state_next = rsa_mexp_pkg::ST_SQR_GO;
        end
      end
      rsa_mexp_pkg::ST_MUL_GO:   state_next = rsa_mexp_pkg::ST_MUL_WAIT;
      rsa_mexp_pkg::ST_MUL_WAIT: begin
        if (mm_stat.done) state_next = rsa_mexp_pkg::ST_SQR_GO;
      end
      rsa_mexp_pkg::ST_SQR_GO:   state_next = rsa_mexp_pkg::ST_SQR_WAIT;
      rsa_mexp_pkg::ST_SQR_WAIT: begin
        if (mm_stat.done) state_next = rsa_mexp_pkg::ST_BIT;
      end
      rsa_mexp_pkg::ST_DONE: begin
        if (res_ready) state_next = rsa_mexp_pkg::ST_IDLE;
      end
      default: state_next = rsa_mexp_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshakes and multiplier operands
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mm_start  = 1'b0;
    mm_x      = base;
    mm_y      = base;
    unique case (state)
      rsa_mexp_pkg::ST_IDLE:   in_ready = 1'b1;
      rsa_mexp_pkg::ST_RED_GO: begin
        mm_start = 1'b1;
        mm_x     = WORD_BITS'(1);
      end
      rsa_mexp_pkg::ST_MUL_GO: begin
        mm_start = 1'b1;
        mm_x     = acc;
      end
      rsa_mexp_pkg::ST_SQR_GO: mm_start = 1'b1;
      rsa_mexp_pkg::ST_DONE:   res_valid = 1'b1;
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  assign mm_n = modulus;

  // Datapath: load the item, then take back each product
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q    <= in_func;
      hash_q    <= in_hash;
      bits_left <= BitsW'(WORD_BITS);
      acc       <= small_mod ? '0 : WORD_BITS'(1);
      unique case (in_func)
        rsa_mexp_pkg::FN_ENCRYPT: begin
          base <= in_value & WORD_BITS'(rsa_mexp_pkg::BYTE_MASK);
          expo <= public_exponent;
        end
        rsa_mexp_pkg::FN_DECRYPT: begin
          base <= in_value;
          expo <= private_exponent;
        end
        rsa_mexp_pkg::FN_SIGN: begin
          base <= in_hash;
          expo <= private_exponent;
        end
        default: begin
          base <= in_value;
          expo <= public_exponent;
        end
      endcase
    end else if (mm_stat.done) begin
      case (state)
        rsa_mexp_pkg::ST_RED_WAIT: base <= mm_p;
        rsa_mexp_pkg::ST_MUL_WAIT: acc  <= mm_p;
        rsa_mexp_pkg::ST_SQR_WAIT: begin
          base      <= mm_p;
          expo      <= expo >> 1;
          bits_left <= bits_left - 1'b1;
        end
        default: base <= base;
      endcase
    end
  end

  // Result formatting
  assign res_word  = (func_q == rsa_mexp_pkg::FN_DECRYPT)
                     ? (acc & WORD_BITS'(rsa_mexp_pkg::BYTE_MASK)) : acc;
  assign res_match = (func_q == rsa_mexp_pkg::FN_VERIFY) && (acc == hash_q);

  // Start the multiplier only when it is free
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    mm_start |-> !mm_stat.busy)
    else $error("multiplier started while busy");

  // A finished product always lands in a waiting state
  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    mm_stat.done |-> (state == rsa_mexp_pkg::ST_RED_WAIT ||
                      state == rsa_mexp_pkg::ST_MUL_WAIT ||
                      state == rsa_mexp_pkg::ST_SQR_WAIT))
    else $error("product finished with no step waiting");

  // Accumulator stays reduced between exponent bits
  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == rsa_mexp_pkg::ST_BIT) |-> (acc < modulus))
    else $error("accumulator not reduced modulo n");

endmodule

[hdl/rsa_modular_exponentiation_unit.sv]
// Top level of the RSA modular exponentiation unit: registers, sequencer, output stage.
//
// Usage:
//   Configuration goes through the APB-style port: modulus at 0x0, public exponent
//   at 0x4, private exponent at 0x8; pready is always high and reads return the
//   register. Write only while no item is in flight.
//   An input item (s_tuser = operation, s_tdata = value and hash word) is taken
//   when s_tvalid and s_tready are high; the block then works on it alone.
//   One result (m_tdata = result, then the match flag) follows each item.
// Cost of an item:
//   Every modular product runs on one shared bit-serial multiplier. An item costs
//   one reduction of the base, one square per bit of the exponent word and one
//   multiply per set exponent bit, plus a decision step per bit. A modulus below
//   two gives a result of 0.
// Reset and stalls:
//   rst loads the key of primes 101 and 103 (n = 10403, e = 7, d = 8743) and
//   empties the pipeline. The output register holds a result until m_tready;
//   the next item is taken meanwhile and waits in the sequencer once done.
module rsa_modular_exponentiation_unit #(
  parameter int WORD_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // APB-style configuration
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [3:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  // Input items
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // s_tdata: value, hash_word, zero padding
  input  logic [((2*WORD_BITS+7)/8)*8-1:0]       s_tdata,
  // s_tuser: func
  input  logic [1:0]                             s_tuser,
  // Result items
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // m_tdata: result, match, zero padding
  output logic [((WORD_BITS+1+7)/8)*8-1:0]       m_tdata
);

  localparam int OutW = ((WORD_BITS + 1 + 7) / 8) * 8;

  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] public_exponent;
  logic [WORD_BITS-1:0] private_exponent;
  logic                 cfg_write;
  rsa_mexp_pkg::reg_idx_t cfg_idx;

  logic                 res_valid;
  logic                 res_ready;
  logic [WORD_BITS-1:0] res_word;
  logic                 res_match;

  logic                     mm_start;
  logic [WORD_BITS-1:0]     mm_x;
  logic [WORD_BITS-1:0]     mm_y;
  logic [WORD_BITS-1:0]     mm_n;
  logic [WORD_BITS-1:0]     mm_p;
  rsa_mexp_pkg::mm_status_t mm_stat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = rsa_mexp_pkg::reg_idx_t'(paddr[3:2]);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= rsa_mexp_pkg::RESET_MODULUS[WORD_BITS-1:0];
      public_exponent  <= rsa_mexp_pkg::RESET_PUBLIC_EXP[WORD_BITS-1:0];
      private_exponent <= rsa_mexp_pkg::RESET_PRIVATE_EXP[WORD_BITS-1:0];
    end else if (cfg_write) begin
      unique case (cfg_idx)
        rsa_mexp_pkg::REG_MODULUS:     modulus          <= pwdata[WORD_BITS-1:0];
        rsa_mexp_pkg::REG_PUBLIC_EXP:  public_exponent  <= pwdata[WORD_BITS-1:0];
        rsa_mexp_pkg::REG_PRIVATE_EXP: private_exponent <= pwdata[WORD_BITS-1:0];
        default: modulus <= modulus;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_idx)
      rsa_mexp_pkg::REG_MODULUS:     prdata = 32'(modulus);
      rsa_mexp_pkg::REG_PUBLIC_EXP:  prdata = 32'(public_exponent);
      rsa_mexp_pkg::REG_PRIVATE_EXP: prdata = 32'(private_exponent);
      default:                       prdata = '0;
    endcase
  end

  rsa_mexp_seq #(
    .WORD_BITS (WORD_BITS)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .in_func          (rsa_mexp_pkg::func_t'(s_tuser)),
    .in_value         (s_tdata[WORD_BITS-1:0]),
    .in_hash          (s_tdata[2*WORD_BITS-1:WORD_BITS]),
    .modulus          (modulus),
    .public_exponent  (public_exponent),
    .private_exponent (private_exponent),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res_word         (res_word),
    .res_match        (res_match),
    .mm_start         (mm_start),
    .mm_x             (mm_x),
    .mm_y             (mm_y),
    .mm_n             (mm_n),
    .mm_stat          (mm_stat),
    .mm_p             (mm_p)
  );

  rsa_mexp_modmul #(
    .WORD_BITS (WORD_BITS)
  ) u_modmul (
    .clk   (clk),
    .rst   (rst),
    .start (mm_start),
    .x     (mm_x),
    .y     (mm_y),
    .n     (mm_n),
    .stat  (mm_stat),
    .p     (mm_p)
  );

  // Output register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= OutW'({res_match, res_word});
    end
  end

endmodule
